FILE: rtl/core/vn3_pkg.sv
// ----------------------------------------------------------------------------
// vn3_pkg
// Shared constants for the 3D vector normalizer.
// ----------------------------------------------------------------------------
package vn3_pkg;

	localparam int UNIT_FRAC  = 30;             // fraction bits of a unit component
	localparam int UNIT_BITS  = 32;             // width of a unit component
	localparam int QUO_BITS   = UNIT_FRAC + 1;  // magnitude 0 .. 2^30
	localparam int NSTEP      = UNIT_FRAC + 1;  // one root/divide step per quotient bit
	localparam int CFG_BITS   = 16;
	localparam logic [CFG_BITS-1:0] MINLEN_RESET = 16'd1;

	typedef logic [QUO_BITS-1:0] quo_t;

endpackage

FILE: rtl/core/vector_normalize_3d.sv
// ----------------------------------------------------------------------------
// vector_normalize_3d
// Scales a signed fixed-point 3D vector to unit length, Q2.30, truncated.
// ----------------------------------------------------------------------------
//
//  channel | signals                                  | dir
//  --------+------------------------------------------+-----
//  in      | in_valid, in_ready, x_in, y_in, z_in     | in
//  out     | out_valid, out_ready, x_unit, y_unit,    | out
//          | z_unit, normalized_ok                    |
//  cfg     | cfg_we, cfg_data (min_length)            | in
//
// One word per cycle while the output does not stall. Stages: magnitude,
// squares, sum and threshold, 31 combined root/divide steps (one quotient bit each), output.
// arst_n clears all valid bits and sets min_length to 1.
// A stall on the output freezes the whole pipeline; in_ready follows
// out_ready whenever the output register holds a word.
//
module vector_normalize_3d #(
	parameter int COMPONENT_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [vn3_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [COMPONENT_BITS-1:0]   x_in,
	input  logic signed [COMPONENT_BITS-1:0]   y_in,
	input  logic signed [COMPONENT_BITS-1:0]   z_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [vn3_pkg::UNIT_BITS-1:0] x_unit,
	output logic signed [vn3_pkg::UNIT_BITS-1:0] y_unit,
	output logic signed [vn3_pkg::UNIT_BITS-1:0] z_unit,
	output logic                               normalized_ok
);
	import vn3_pkg::*;

	localparam int CB = COMPONENT_BITS;
	localparam int SW = 2 * CB;                  // sum of squares
	localparam int RW = 2 * CB + 2 * UNIT_FRAC;  // remainder m^2*2^60 - q^2*S
	localparam int PW = 2 * CB + QUO_BITS;       // running q*S
	localparam int DW = 2 * CB + 2 * UNIT_FRAC + 3;

	logic [CFG_BITS-1:0] min_length_q;
	logic                en;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MINLEN_RESET;
		end else if (cfg_we) begin
			min_length_q <= cfg_data;
		end
	end

	// stage 1: magnitudes and signs
	logic          vld_s1;
	logic [CB-1:0] mag_s1 [3];
	logic [2:0]    neg_s1;
	logic [CB-1:0] cin [3];

	assign cin[0] = x_in;
	assign cin[1] = y_in;
	assign cin[2] = z_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				neg_s1[c] <= cin[c][CB-1];
				// the most negative value negates onto itself, which is its magnitude
				mag_s1[c] <= cin[c][CB-1] ? (~cin[c] + CB'(1)) : cin[c];
			end
		end
	end

	// stage 2: squares
	logic                  vld_s2;
	logic [SW-1:0]         sq_s2 [3];
	logic [2:0]            neg_s2;
	logic [2*CFG_BITS-1:0] thr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				sq_s2[c] <= SW'(mag_s1[c]) * SW'(mag_s1[c]);
			end
			neg_s2 <= neg_s1;
			thr_s2 <= (2*CFG_BITS)'(min_length_q) * (2*CFG_BITS)'(min_length_q);
		end
	end

	// root/divide steps: find the largest q <= 2^30 with q^2*S <= m^2*2^60,
	// one bit per stage, keeping rem = m^2*2^60 - q^2*S and prod = q*S
	logic          vld_si  [NSTEP+1];
	logic          ok_si   [NSTEP+1];
	logic [SW-1:0] sum_si  [NSTEP+1];
	logic [2:0]    neg_si  [NSTEP+1];
	logic [RW-1:0] rem_si  [NSTEP+1][3];
	logic [PW-1:0] prod_si [NSTEP+1][3];
	quo_t          q_si    [NSTEP+1][3];

	// stage 3: length squared and threshold test, seeds the first step
	logic [SW-1:0] sum_c;

	assign sum_c = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_si[0] <= 1'b0;
		end else if (en) begin
			vld_si[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_si[0] <= sum_c;
			ok_si[0]  <= (sum_c != '0) && (sum_c >= SW'(thr_s2));
			neg_si[0] <= neg_s2;
			for (int c = 0; c < 3; c++) begin
				rem_si[0][c]  <= RW'(sq_s2[c]) << (2 * UNIT_FRAC);
				prod_si[0][c] <= '0;
				q_si[0][c]    <= '0;
			end
		end
	end

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		localparam int B = UNIT_FRAC - k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_si[k+1] <= 1'b0;
			end else if (en) begin
				vld_si[k+1] <= vld_si[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ok_si[k+1]  <= ok_si[k];
				sum_si[k+1] <= sum_si[k];
				neg_si[k+1] <= neg_si[k];
			end
		end

		for (genvar c = 0; c < 3; c++) begin : g_lane
			logic [DW-1:0] dlt;
			logic          take;

			// (q + 2^B)^2*S - q^2*S = 2^(B+1)*q*S + 2^(2B)*S
			assign dlt  = (DW'(prod_si[k][c]) << (B + 1)) + (DW'(sum_si[k]) << (2 * B));
			// once q reaches 2^30 no lower bit may be added
			assign take = ((B == UNIT_FRAC) || !q_si[k][c][UNIT_FRAC])
				&& (dlt <= DW'(rem_si[k][c]));

			always_ff @(posedge clk) begin
				if (en) begin
					if (take) begin
						rem_si[k+1][c]  <= rem_si[k][c] - RW'(dlt);
						prod_si[k+1][c] <= prod_si[k][c] + (PW'(sum_si[k]) << B);
						q_si[k+1][c]    <= q_si[k][c] | (QUO_BITS'(1) << B);
					end else begin
						rem_si[k+1][c]  <= rem_si[k][c];
						prod_si[k+1][c] <= prod_si[k][c];
						q_si[k+1][c]    <= q_si[k][c];
					end
				end
			end
		end
	end

	// output register: apply sign, zero on rejection
	logic [UNIT_BITS-1:0] unit_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (!ok_si[NSTEP]) begin
				unit_c[c] = '0;
			end else if (neg_si[NSTEP][c]) begin
				unit_c[c] = UNIT_BITS'(0) - UNIT_BITS'(q_si[NSTEP][c]);
			end else begin
				unit_c[c] = UNIT_BITS'(q_si[NSTEP][c]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_si[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_unit        <= unit_c[0];
			y_unit        <= unit_c[1];
			z_unit        <= unit_c[2];
			normalized_ok <= ok_si[NSTEP];
		end
	end

	// rejected words carry zero components
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !normalized_ok |-> x_unit == '0 && y_unit == '0 && z_unit == '0)
		else $error("rejected word has nonzero components");

	// x_unit stays within -2^30 .. 2^30
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $signed(x_unit) <= $signed(UNIT_BITS'(1) << UNIT_FRAC)
			&& $signed(x_unit) >= -$signed(UNIT_BITS'(1) << UNIT_FRAC))
		else $error("x_unit out of unit range");

	// a stalled output freezes the pipeline: nothing is taken at the input
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output stalled");

	// an enabled word moves from the last step into the output register in the next cycle
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_si[NSTEP] |=> out_valid)
		else $error("word lost between last step and output");

endmodule

FILE: test/tb_vector_normalize_3d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_normalize_3d
// Self-checking bench for the 3D vector normalizer. Vectors are fed with
// random gaps, results are drained with random stalls and compared against
// an exact integer predictor, across several min_length settings.
// ----------------------------------------------------------------------------
module tb_vector_normalize_3d;
	import vn3_pkg::*;

	localparam int LIMIT = 5000;
	localparam int TAIL  = 60;

	typedef struct {
		logic [31:0] x, y, z;
	} vec_t;

	typedef struct {
		logic [UNIT_BITS-1:0] x, y, z;
		logic                 ok;
	} unit_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_BITS-1:0] cfg_data = '0;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [31:0] x_in, y_in, z_in;
	logic signed [UNIT_BITS-1:0] x_unit, y_unit, z_unit;
	logic normalized_ok;

	vec_t  pending_vecs[$];
	unit_t expected_units[$];
	logic [15:0] min_len = MINLEN_RESET;
	int errors = 0;
	int send_wait = 0;
	int drain_wait = 0;
	int idle_cycles = 0;

	vector_normalize_3d #(.COMPONENT_BITS(32)) DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.x_in(x_in), .y_in(y_in), .z_in(z_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.x_unit(x_unit), .y_unit(y_unit), .z_unit(z_unit),
		.normalized_ok(normalized_ok)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] magnitude(logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	// largest q <= 2^30 with q*q*s <= m*m*2^60
	function automatic logic [31:0] unit_mag(logic [31:0] m, logic [63:0] s);
		logic [127:0] target, lhs, t, s_w;
		logic [31:0] q;
		q = '0;
		s_w = 128'(s);
		target = (128'(m) * 128'(m)) << (2 * UNIT_FRAC);
		for (int b = UNIT_FRAC; b >= 0; b--) begin
			t = 128'(q | (32'd1 << b));
			if (t <= (128'd1 << UNIT_FRAC)) begin
				lhs = t * t * s_w;
				if (lhs <= target)
					q = t[31:0];
			end
		end
		return q;
	endfunction

	function automatic unit_t normalize(vec_t v);
		unit_t r;
		logic [31:0] mx, my, mz;
		logic [63:0] s;
		mx = magnitude(v.x);
		my = magnitude(v.y);
		mz = magnitude(v.z);
		s = 64'(mx) * mx + 64'(my) * my + 64'(mz) * mz;
		r = '{default: '0};
		if (s == 0 || s < 64'(min_len) * 64'(min_len))
			return r;
		r.x = v.x[31] ? -unit_mag(mx, s) : unit_mag(mx, s);
		r.y = v.y[31] ? -unit_mag(my, s) : unit_mag(my, s);
		r.z = v.z[31] ? -unit_mag(mz, s) : unit_mag(mz, s);
		r.ok = 1'b1;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int draw_wait();
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
	endfunction

	// driver: advance to the next word once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		vec_t v;
		if (!arst_n) begin
			in_valid <= 1'b0;
			x_in <= '0;
			y_in <= '0;
			z_in <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_units.push_back(normalize('{x_in, y_in, z_in}));
				send_wait = draw_wait();
			end
			if (!in_valid || in_ready) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (pending_vecs.size() > 0) begin
					v = pending_vecs.pop_front();
					in_valid <= 1'b1;
					x_in <= v.x;
					y_in <= v.y;
					z_in <= v.z;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each word taken, then stall for a random while
	always @(posedge clk or negedge arst_n) begin
		unit_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_units.size() == 0) begin
					report("unexpected word", x_unit, '0);
				end else begin
					e = expected_units.pop_front();
					if (x_unit !== e.x) report("x_unit", x_unit, e.x);
					if (y_unit !== e.y) report("y_unit", y_unit, e.y);
					if (z_unit !== e.z) report("z_unit", z_unit, e.z);
					if (normalized_ok !== e.ok)
						report("normalized_ok", 32'(normalized_ok), 32'(e.ok));
				end
				drain_wait = draw_wait();
			end
			if (drain_wait > 0) begin
				drain_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic add_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		pending_vecs.push_back('{x, y, z});
	endtask

	function automatic logic [31:0] rand_comp(int mode);
		logic [31:0] pick[5];
		logic [31:0] v;
		pick = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0};
		case (mode)
			0, 1, 2, 3: v = $urandom;
			4, 5: begin
				v = $urandom_range(0, 300);
				if ($urandom_range(0, 1)) v = -v;
			end
			6: v = pick[$urandom_range(0, 4)];
			default: v = $urandom >>> $urandom_range(0, 31);
		endcase
		return v;
	endfunction

	task automatic add_random(int count);
		int mode, axis;
		logic [31:0] c[3];
		repeat (count) begin
			mode = $urandom_range(0, 9);
			if (mode == 9) begin
				// one component carries the whole length
				axis = $urandom_range(0, 2);
				c = '{32'd0, 32'd0, 32'd0};
				c[axis] = rand_comp($urandom_range(0, 6));
			end else begin
				foreach (c[i]) c[i] = rand_comp(mode);
			end
			add_vec(c[0], c[1], c[2]);
		end
	endtask

	task automatic drain();
		@(posedge clk);
		#1;
		while (pending_vecs.size() > 0 || in_valid || expected_units.size() > 0) begin
			@(posedge clk);
			#1;
		end
		repeat (TAIL) @(posedge clk);
	endtask

	task automatic write_min(logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		min_len = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: only the zero vector fails
		add_vec(0, 0, 0);
		add_vec(1, 0, 0);
		add_vec(0, 0, 32'hFFFF_FFFF);
		add_vec(32'h8000_0000, 0, 0);
		add_vec(0, 32'h7FFF_FFFF, 0);
		add_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_vec(32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
		add_vec(3, -4, 12);
		drain();

		// short vectors around the threshold
		write_min(16'd100);
		add_vec(99, 0, 0);
		add_vec(100, 0, 0);
		add_vec(60, -80, 0);
		add_vec(57, 57, 57);
		add_vec(58, 58, 57);
		add_vec(0, 0, 0);
		drain();

		write_min(16'd0);
		add_vec(0, 0, 0);
		add_vec(0, 1, 0);
		add_random(480);
		drain();

		write_min(16'hFFFF);
		add_vec(32'h0000_FFFE, 0, 0);
		add_vec(0, 0, 32'hFFFF_0001);
		add_vec(32'h0001_0000, 0, 0);
		add_random(480);
		drain();

		write_min(16'($urandom_range(2, 65534)));
		add_random(480);
		drain();

		write_min(16'd1);
		add_random(480);
		drain();

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: vector_normalize_3d.f
rtl/core/vn3_pkg.sv
rtl/core/vector_normalize_3d.sv
test/tb_vector_normalize_3d.sv
